// File: hdl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared codes, constants and types of the touchpad packet decoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_INVERT_Y  = 2'd2;

   // packet_mode codes
   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_REL = 2'd1;
   localparam logic [1:0] MODE_ABS = 2'd2;

   // request action codes
   localparam logic [1:0] ACT_BYTE   = 2'd0;
   localparam logic [1:0] ACT_ERROR  = 2'd1;
   localparam logic [1:0] ACT_REPORT = 2'd2;

   // result kinds
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_GUEST  = 1'b1;

   // packet framing
   localparam logic [2:0] REL_BYTES = 3'd3;
   localparam logic [2:0] ABS_BYTES = 3'd6;
   localparam logic [7:0] ABS_HEAD_MASK  = 8'hC8;
   localparam logic [7:0] ABS_HEAD0      = 8'h80;
   localparam logic [7:0] ABS_HEAD3      = 8'hC0;
   localparam logic [3:0] W_PASS_THROUGH = 4'd3;

   // reset values
   localparam logic [7:0] THRESHOLD_RESET = 8'd30;

   // motion scaling
   localparam int MOTION_DIVISOR_DEFAULT = 8;

   // one result item
   typedef struct packed {
      logic               result_kind;
      logic [2:0]         button_bits;
      logic signed [7:0]  report_x;
      logic signed [7:0]  report_y;
      logic [7:0]         guest_first;
      logic [7:0]         guest_second;
      logic [7:0]         guest_third;
      logic [15:0]        resync_count;
      logic [15:0]        touch_count;
      logic [15:0]        guest_count;
   } result_type;

   // clamp a widened sum to +-127
   function automatic logic signed [7:0] sat127(input logic signed [14:0] v);
      logic signed [7:0] r;
      if (v > 15'sd127) begin
         r = 8'sd127;
      end else if (v < -15'sd127) begin
         r = -8'sd127;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/touchpad_packet_decoder.sv
// ----------------------------------------------------------------------------
// touchpad_packet_decoder
// PS/2 touchpad byte assembler with relative and absolute packet decoding.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one item per cycle while req_stall is low: a received
//   byte, a receive error or a take-report request. rsp channel carries the
//   accumulated report (answer to take-report) and pass-through guest frames.
//   An item is taken at an edge with req_valid high and req_stall low; its
//   whole decode (packet check, W split, delta scaling, saturating sums) is
//   done in that cycle, and its result, if any, shows on rsp the next cycle
//   when the output queue is empty.
//   Throughput is one item per cycle while req_stall is low. A two-entry
//   output queue (result register plus skid register) lets a new item in
//   while a result waits; req_stall is high while both entries hold results,
//   so it drops in the cycle after rsp takes one. Motion divide by
//   MOTION_DIVISOR is a 13 by 21 bit reciprocal multiply. Reset (synchronous,
//   active high) clears the packet fill, finger state, sums and counters,
//   sets packet_mode to off and touch_threshold to 30, and empties the output
//   queue. Registers sit on an APB-style port at byte addresses 0, 4 and 8,
//   written by the user only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module touchpad_packet_decoder #(
   parameter int MOTION_DIVISOR = tpd_pkg::MOTION_DIVISOR_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_data_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [2:0]         rsp_button_bits,
   output logic signed [7:0]  rsp_report_x,
   output logic signed [7:0]  rsp_report_y,
   output logic [7:0]         rsp_guest_first,
   output logic [7:0]         rsp_guest_second,
   output logic [7:0]         rsp_guest_third,
   output logic [15:0]        rsp_resync_count,
   output logic [15:0]        rsp_touch_count,
   output logic [15:0]        rsp_guest_count,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import tpd_pkg::*;

   // reciprocal for the motion divide, exact for magnitudes below 2**13
   localparam int RECIP_SHIFT = 20;
   localparam logic [20:0] RECIP = 21'((2**RECIP_SHIFT + MOTION_DIVISOR - 1) / MOTION_DIVISOR);

   // signed divide truncated toward zero
   function automatic logic signed [13:0] div_motion(input logic signed [13:0] v);
      logic [13:0] mag;
      logic [33:0] prod;
      logic [12:0] q;
      mag  = v[13] ? 14'(-v) : 14'(v);
      prod = 34'(mag[12:0]) * 34'(RECIP);
      q    = prod[RECIP_SHIFT +: 13];
      return v[13] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   // configuration registers
   logic [1:0]         mode_ff, mode_in;
   logic [7:0]         thresh_ff, thresh_in;
   logic               invert_ff, invert_in;

   // decoder state
   logic [7:0]         bytes_ff [6];
   logic [7:0]         bytes_in [6];
   logic [2:0]         fill_ff, fill_in;
   logic               finger_ff, finger_in;
   logic [12:0]        prev_x_ff, prev_x_in;
   logic [12:0]        prev_y_ff, prev_y_in;
   logic signed [7:0]  sum_x_ff, sum_x_in;
   logic signed [7:0]  sum_y_ff, sum_y_in;
   logic [2:0]         sum_btn_ff, sum_btn_in;
   logic [15:0]        resync_ff, resync_in;
   logic [15:0]        touch_ff, touch_in;
   logic [15:0]        guest_ff, guest_in;

   // output queue
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   result_type         skid_ff, skid_in;

   logic               accept;
   logic               cfg_write;
   logic               push;
   logic               pop;
   result_type         res;
   logic [2:0]         want;
   logic [2:0]         fill_eff;
   logic               full;
   logic [7:0]         pkt [6];
   logic               abs_ok;
   logic [3:0]         w_val;
   logic [12:0]        x_abs, y_abs;
   logic signed [13:0] diff_x, diff_y;
   logic signed [13:0] dx_f, dy_q, dy_f;
   logic signed [8:0]  rel_dx, rel_dy;
   logic               touching;

   // handshakes
   assign accept    = req_valid & ~req_stall;
   assign req_stall = skid_valid_ff;
   assign pop       = out_valid_ff & ~rsp_stall;
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   // register readback
   always_comb begin
      prdata = '0;
      case (paddr[3:2])
         REG_MODE:      prdata = 32'(mode_ff);
         REG_THRESHOLD: prdata = 32'(thresh_ff);
         REG_INVERT_Y:  prdata = 32'(invert_ff);
         default:       prdata = '0;
      endcase
   end

   // packet as it stands with the new byte written in
   assign want     = (mode_ff == MODE_ABS) ? ABS_BYTES : REL_BYTES;
   assign fill_eff = (fill_ff >= want) ? 3'd0 : fill_ff;
   assign full     = (fill_eff == want - 3'd1);
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pkt[i] = (fill_eff == 3'(i)) ? req_data_byte : bytes_ff[i];
      end
   end

   // absolute frame fields
   assign abs_ok = ((pkt[0] & ABS_HEAD_MASK) == ABS_HEAD0) &&
                   ((pkt[3] & ABS_HEAD_MASK) == ABS_HEAD3);
   assign w_val  = {pkt[0][5:4], pkt[0][2], pkt[3][2]};
   assign x_abs  = {pkt[3][4], pkt[1][3:0], pkt[4]};
   assign y_abs  = {pkt[3][5], pkt[1][7:4], pkt[5]};
   assign touching = pkt[2] > thresh_ff;

   // scaled finger motion
   assign diff_x = $signed({1'b0, x_abs}) - $signed({1'b0, prev_x_ff});
   assign diff_y = $signed({1'b0, prev_y_ff}) - $signed({1'b0, y_abs});
   assign dx_f   = div_motion(diff_x);
   assign dy_q   = div_motion(diff_y);
   assign dy_f   = invert_ff ? -dy_q : dy_q;

   // relative frame motion, 9-bit signed
   assign rel_dx = $signed({pkt[0][4], pkt[1]});
   assign rel_dy = $signed({pkt[0][5], pkt[2]});

   // next state of registers and decoder
   always_comb begin
      mode_in    = mode_ff;
      thresh_in  = thresh_ff;
      invert_in  = invert_ff;
      bytes_in   = bytes_ff;
      fill_in    = fill_ff;
      finger_in  = finger_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      sum_btn_in = sum_btn_ff;
      resync_in  = resync_ff;
      touch_in   = touch_ff;
      guest_in   = guest_ff;
      push       = 1'b0;
      res        = '0;

      // configuration write
      if (cfg_write) begin
         case (paddr[3:2])
            REG_MODE: begin
               mode_in = pwdata[1:0];
               fill_in = 3'd0;
            end
            REG_THRESHOLD: thresh_in = pwdata[7:0];
            REG_INVERT_Y:  invert_in = pwdata[0];
            default: ;
         endcase
      end

      // one request item
      if (accept) begin
         case (req_action)
            ACT_ERROR: begin
               fill_in = 3'd0;
            end
            ACT_REPORT: begin
               push            = 1'b1;
               res.result_kind = KIND_REPORT;
               res.button_bits = sum_btn_ff;
               res.report_x    = sum_x_ff;
               res.report_y    = sum_y_ff;
               sum_x_in        = '0;
               sum_y_in        = '0;
               sum_btn_in      = '0;
            end
            ACT_BYTE: begin
               if (mode_ff == MODE_REL || mode_ff == MODE_ABS) begin
                  bytes_in = pkt;
                  fill_in  = fill_eff + 3'd1;
                  if (full && mode_ff == MODE_ABS) begin
                     if (!abs_ok) begin
                        // drop first byte and resync
                        for (int i = 0; i < 5; i++) begin
                           bytes_in[i] = pkt[i + 1];
                        end
                        fill_in   = 3'd5;
                        resync_in = resync_ff + 16'd1;
                     end else if (w_val == W_PASS_THROUGH) begin
                        fill_in          = 3'd0;
                        guest_in         = guest_ff + 16'd1;
                        push             = 1'b1;
                        res.result_kind  = KIND_GUEST;
                        res.guest_first  = pkt[1];
                        res.guest_second = pkt[4];
                        res.guest_third  = pkt[5];
                     end else begin
                        // finger frame
                        fill_in    = 3'd0;
                        touch_in   = touch_ff + 16'd1;
                        sum_btn_in = sum_btn_ff | {1'b0, pkt[0][1:0]};
                        if (touching) begin
                           if (finger_ff) begin
                              sum_x_in = sat127(15'(sum_x_ff) + 15'(dx_f));
                              sum_y_in = sat127(15'(sum_y_ff) + 15'(dy_f));
                           end
                           finger_in = 1'b1;
                           prev_x_in = x_abs;
                           prev_y_in = y_abs;
                        end else begin
                           finger_in = 1'b0;
                        end
                     end
                  end else if (full) begin
                     if (!pkt[0][3]) begin
                        bytes_in[0] = pkt[1];
                        bytes_in[1] = pkt[2];
                        fill_in     = 3'd2;
                        resync_in   = resync_ff + 16'd1;
                     end else begin
                        fill_in    = 3'd0;
                        sum_btn_in = sum_btn_ff | pkt[0][2:0];
                        sum_x_in   = sat127(15'(sum_x_ff) + 15'(rel_dx));
                        sum_y_in   = sat127(15'(sum_y_ff) - 15'(rel_dy));
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // counters as left by this item
      res.resync_count = resync_in;
      res.touch_count  = touch_in;
      res.guest_count  = guest_in;
   end

   // output queue: result register fed from skid or new result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OFF;
         thresh_ff     <= THRESHOLD_RESET;
         invert_ff     <= 1'b0;
         fill_ff       <= 3'd0;
         finger_ff     <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_btn_ff    <= '0;
         resync_ff     <= '0;
         touch_ff      <= '0;
         guest_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         thresh_ff     <= thresh_in;
         invert_ff     <= invert_in;
         fill_ff       <= fill_in;
         finger_ff     <= finger_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         sum_btn_ff    <= sum_btn_in;
         resync_ff     <= resync_in;
         touch_ff      <= touch_in;
         guest_ff      <= guest_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      out_ff   <= out_in;
      skid_ff  <= skid_in;
   end

   // result ports
   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.result_kind;
   assign rsp_button_bits  = out_ff.button_bits;
   assign rsp_report_x     = out_ff.report_x;
   assign rsp_report_y     = out_ff.report_y;
   assign rsp_guest_first  = out_ff.guest_first;
   assign rsp_guest_second = out_ff.guest_second;
   assign rsp_guest_third  = out_ff.guest_third;
   assign rsp_resync_count = out_ff.resync_count;
   assign rsp_touch_count  = out_ff.touch_count;
   assign rsp_guest_count  = out_ff.guest_count;

endmodule
